FILE: src/int16_decimal_ascii_formatter_top_defines.svh
// Assertion macros shared by the formatter RTL.
// Each assertion is clocked by clk and disabled while rst_n is low.
`ifndef INT16_DECIMAL_ASCII_FORMATTER_TOP_DEFINES_SVH
`define INT16_DECIMAL_ASCII_FORMATTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I2A_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2A_ASSERT_NEVER(label, cond, msg) \
    `I2A_ASSERT(label, !(cond), msg)
`else
`define I2A_ASSERT(label, prop, msg)
`define I2A_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: src/i2a_pkg.sv
// Package for the signed 16-bit decimal ASCII formatter.
// Holds widths, character codes, the scaling constant and shared types.
package i2a_pkg;

    localparam int VALUE_W  = 16;
    localparam int MAG_W    = 16;
    localparam int BYTE_W   = 8;
    localparam int DIGIT_W  = 4;

    // The magnitude is scaled by ceil(2^32 / 10000). The integer part of the
    // product is the ten-thousands digit, and each multiply of the fraction
    // by ten brings out the next digit. The error stays below one part in
    // 10^4 for every magnitude up to 32768, so no digit is ever off by one.
    localparam int FRAC_W   = 32;
    localparam int RECIP_W  = 19;
    localparam logic [RECIP_W-1:0] RECIP = 19'd429497;
    localparam int PROD_W   = MAG_W + RECIP_W;
    localparam int ACC_W    = FRAC_W + DIGIT_W;

    localparam int IDX_W    = 3;
    localparam logic [IDX_W-1:0] LAST_DIGIT_IDX = 3'd4;
    localparam logic [IDX_W-1:0] TERM_IDX       = 3'd5;

    localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] ASCII_NUL   = 8'h00;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] scaled;
    } i2a_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } i2a_qstat_t;

endpackage

FILE: src/i2a_if.sv
// Channel interfaces of the formatter: the value input and the text output.
// Depends on i2a_pkg for the payload widths.
interface i2a_value_if
    import i2a_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2a_text_if
    import i2a_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: src/int16_decimal_ascii_formatter_top.sv
// Signed 16-bit to decimal ASCII formatter, top level; uses i2a_pkg and i2a_if.
// Path: the front end registers a value, the queue stores it, the sequencer pops it
// and the output byte register offers its bytes, minus sign first for a negative value.
// The sequencer takes one step per output byte or skipped leading zero and holds while
// an offered byte is not taken; it pops the next entry in the step of the terminator.
// Reset: rst_n is asynchronous and active low; it empties the queue and drops all output.
module int16_decimal_ascii_formatter_top
    import i2a_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_value_if.sink   value_ch,
    i2a_text_if.source  text_ch
);

    logic        push;
    logic        pop;
    i2a_entry_t  push_entry;
    i2a_entry_t  pop_entry;
    i2a_qstat_t  qstat;

    i2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_ch   (value_ch),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    i2a_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    i2a_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .text_ch   (text_ch)
    );

endmodule

FILE: src/i2a_front.sv
// Front end: accepts a value, splits off the sign and scales the magnitude.
// Depends on i2a_pkg and the i2a_value_if interface.
module i2a_front
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_value_if.sink   value_ch,
    input  i2a_qstat_t  qstat,
    output logic        push,
    output i2a_entry_t  push_entry
);

    logic              held_reg;
    logic              held_next;
    logic              neg_reg;
    logic              neg_next;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  mag_next;
    logic [MAG_W-1:0]  raw;
    logic              accept;

    assign push           = held_reg && !qstat.full;
    assign value_ch.ready = !held_reg || push;
    assign accept         = value_ch.valid && value_ch.ready;
    assign raw            = MAG_W'(unsigned'(value_ch.value));

    always_comb
    begin
        held_next = held_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        if (push)
        begin
            held_next = 1'b0;
        end
        if (accept)
        begin
            held_next = 1'b1;
            neg_next  = raw[MAG_W-1];
            // Two's complement negation keeps 32768 as an unsigned magnitude.
            mag_next  = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
    end

    assign push_entry.neg    = neg_reg;
    assign push_entry.scaled = {{RECIP_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, RECIP};

endmodule

FILE: src/i2a_fifo.sv
// Short queue between the front end and the byte sequencer.
// Depends on i2a_pkg and the assertion macro header.
`include "int16_decimal_ascii_formatter_top_defines.svh"
module i2a_fifo
    import i2a_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  i2a_entry_t  push_entry,
    input  logic        pop,
    output i2a_entry_t  pop_entry,
    output i2a_qstat_t  qstat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2a_entry_t        entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `I2A_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count exceeds depth")
    `I2A_ASSERT_NEVER(a_pop_empty, pop && count_reg == '0, "pop from empty queue")
    `I2A_ASSERT_NEVER(a_push_full, push && qstat.full, "push into full queue")

endmodule

FILE: src/i2a_back.sv
// Byte sequencer: walks one queued entry into sign, digits and terminator.
// Depends on i2a_pkg, the i2a_text_if interface and the assertion macros.
`include "int16_decimal_ascii_formatter_top_defines.svh"
module i2a_back
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  i2a_qstat_t  qstat,
    input  i2a_entry_t  pop_entry,
    output logic        pop,
    i2a_text_if.source  text_ch
);

    logic              busy_reg;
    logic              busy_next;
    logic              neg_reg;
    logic              neg_next;
    logic              started_reg;
    logic              started_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              last_reg;
    logic              last_next;

    logic              step;
    logic              emit;
    logic              finish;
    logic              show;
    logic [DIGIT_W-1:0] digit;
    logic [ACC_W-1:0]  frac_ext;
    logic [ACC_W-1:0]  acc_times10;

    assign step        = busy_reg && (!out_valid_reg || text_ch.ready);
    assign finish      = step && !neg_reg && (idx_reg == TERM_IDX);
    assign digit       = acc_reg[ACC_W-1 -: DIGIT_W];
    assign frac_ext    = {{DIGIT_W{1'b0}}, acc_reg[FRAC_W-1:0]};
    // Ten times the fraction: its integer part is the next digit.
    assign acc_times10 = (frac_ext << 3) + (frac_ext << 1);
    // The units digit is always shown, which also covers the value zero.
    assign show        = started_reg || (digit != '0) || (idx_reg == LAST_DIGIT_IDX);
    assign pop         = !qstat.empty && (!busy_reg || finish);

    always_comb
    begin
        busy_next      = busy_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        emit           = 1'b0;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (step)
        begin
            if (neg_reg)
            begin
                emit          = 1'b1;
                out_byte_next = ASCII_MINUS;
                last_next     = 1'b0;
                neg_next      = 1'b0;
            end
            else if (idx_reg == TERM_IDX)
            begin
                emit          = 1'b1;
                out_byte_next = ASCII_NUL;
                last_next     = 1'b1;
                busy_next     = 1'b0;
            end
            else
            begin
                emit          = show;
                out_byte_next = ASCII_ZERO + {{(BYTE_W - DIGIT_W){1'b0}}, digit};
                last_next     = 1'b0;
                started_next  = show;
                acc_next      = acc_times10;
                idx_next      = idx_reg + IDX_W'(1);
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (text_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            busy_next    = 1'b1;
            neg_next     = pop_entry.neg;
            started_next = 1'b0;
            idx_next     = '0;
            acc_next     = ACC_W'(pop_entry.scaled);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign text_ch.valid    = out_valid_reg;
    assign text_ch.out_byte = out_byte_reg;
    assign text_ch.last     = last_reg;

    `I2A_ASSERT(a_sign_first, busy_reg && neg_reg |-> idx_reg == '0, "minus sign after a digit")
    `I2A_ASSERT(a_term_seen, busy_reg && idx_reg == TERM_IDX |-> started_reg, "no digit shown")
    `I2A_ASSERT(a_idx_bound, idx_reg <= TERM_IDX, "digit index out of range")

endmodule

FILE: test/i2a_text_checker.sv
// Checker for the decimal ASCII formatter: predicts the text run of every
// accepted value and compares it with the bytes taken from the text channel.
// Depends on i2a_pkg for widths and character codes.
module i2a_text_checker
    import i2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               value_valid,
    input  logic               value_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               text_valid,
    input  logic               text_ready,
    input  logic [BYTE_W-1:0]  out_byte,
    input  logic               last,
    output int                 fail_count,
    output int                 pending
);

    localparam int unsigned TOP_DECADE = 10000;
    localparam int unsigned RADIX      = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } text_byte_t;

    text_byte_t expected_text[$];

    // Appends the run that one value produces: optional minus sign, digits
    // without leading zeros, then the terminator flagged as last.
    function automatic void predict_text(input logic [VALUE_W-1:0] raw);
        int unsigned magnitude;
        int unsigned divisor;
        int unsigned digit;
        bit          leading;
        leading = 1'b1;
        if (raw == '0)
        begin
            expected_text.push_back('{ch: ASCII_ZERO, last: 1'b0});
            expected_text.push_back('{ch: ASCII_NUL, last: 1'b1});
            return;
        end
        if (raw[VALUE_W-1])
        begin
            expected_text.push_back('{ch: ASCII_MINUS, last: 1'b0});
            // The most negative value yields 32768, which still fits here.
            magnitude = (32'd1 << VALUE_W) - 32'(raw);
        end
        else
        begin
            magnitude = 32'(raw);
        end
        divisor = TOP_DECADE;
        while (divisor != 0)
        begin
            digit     = magnitude / divisor;
            magnitude = magnitude % divisor;
            if (digit != 0)
            begin
                leading = 1'b0;
            end
            if (!leading)
            begin
                expected_text.push_back('{ch: ASCII_ZERO + digit[BYTE_W-1:0], last: 1'b0});
            end
            divisor = divisor / RADIX;
        end
        expected_text.push_back('{ch: ASCII_NUL, last: 1'b1});
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        text_byte_t want;
        if (!rst_n)
        begin
            expected_text.delete();
            pending = 0;
        end
        else
        begin
            // The output side is handled first, so a byte can never be matched
            // against a run predicted in the same cycle.
            if (text_valid && text_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    report_mismatch("unexpected byte", -1, int'({out_byte, last}));
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (want.ch !== out_byte)
                    begin
                        report_mismatch("out_byte", int'(want.ch), int'(out_byte));
                    end
                    if (want.last !== last)
                    begin
                        report_mismatch("last", int'(want.last), int'(last));
                    end
                end
            end
            if (value_valid && value_ready)
            begin
                predict_text(value);
            end
            pending = expected_text.size();
        end
    end

endmodule

FILE: test/tb_int16_decimal_ascii_formatter_top.sv
// Testbench top for the decimal ASCII formatter: clock, reset, value stimulus
// and text back-pressure. Depends on i2a_pkg, i2a_if, the formatter top level
// and i2a_text_checker, which does all prediction and comparison.
module tb_int16_decimal_ascii_formatter_top;
    import i2a_pkg::*;

    localparam int TIMEOUT      = 2000000;
    localparam int RANDOM_ITEMS = 235;
    localparam int SETTLE       = 20;

    localparam int MODE_ALWAYS  = 0;
    localparam int MODE_COIN    = 1;
    localparam int MODE_DUTY    = 2;
    localparam int MODE_SPARSE  = 3;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    i2a_value_if value_ch ();
    i2a_text_if  text_ch ();

    int16_decimal_ascii_formatter_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .text_ch  (text_ch)
    );

    i2a_text_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_ch.valid),
        .value_ready (value_ch.ready),
        .value       (value_ch.value),
        .text_valid  (text_ch.valid),
        .text_ready  (text_ch.ready),
        .out_byte    (text_ch.out_byte),
        .last        (text_ch.last),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #TIMEOUT;
        $display("simulation failed");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        do
        begin
            @(posedge clk);
        end while (!value_ch.ready);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        value_ch.valid <= 1'b0;
        value_ch.value <= VALUE_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_text();
        pause_sender(1);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mix of raw bit patterns, values of every digit count, values right around the
    // decade boundaries where the digit count changes, and magnitudes near 32768.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int decades[5];
        int kind;
        int mag;
        decades = '{1, 10, 100, 1000, 10000};
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            return VALUE_W'($urandom);
        end
        if (kind < 7)
        begin
            mag = $urandom_range(0, decades[$urandom_range(0, 4)] * 10 - 1);
            if (mag > 32767)
            begin
                mag = $urandom_range(0, 32767);
            end
        end
        else if (kind < 9)
        begin
            mag = decades[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
        end
        else
        begin
            mag = 32768 - $urandom_range(0, 3);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            mag = -mag;
        end
        else if (mag > 32767)
        begin
            mag = 32767;
        end
        return mag[VALUE_W-1:0];
    endfunction

    // Receiver stall patterns: always ready, coin flips, a regular duty cycle,
    // and long stalls with single ready cycles.
    initial
    begin
        int mode;
        int span;
        int phase;
        text_ch.ready = 1'b0;
        phase = 0;
        forever
        begin
            mode = $urandom_range(MODE_ALWAYS, MODE_SPARSE);
            span = $urandom_range(20, 120);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    MODE_ALWAYS: text_ch.ready <= 1'b1;
                    MODE_COIN:   text_ch.ready <= ($urandom_range(0, 1) == 1);
                    MODE_DUTY:   text_ch.ready <= ((phase % 5) < 3);
                    default:     text_ch.ready <= ((phase % 9) == 0);
                endcase
                phase++;
            end
        end
    end

    initial
    begin
        int directed_values[];
        int burst;
        rst_n          = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        directed_values = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 999, 1000, 9999,
                            10000, -10000, 12345, -12345, 20000, 32767, -32767,
                            -32768, 21845, -21846, 7, 30001};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_values[i])
        begin
            send_value(directed_values[i][VALUE_W-1:0]);
            if ($urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(1, 5));
            end
        end
        drain_text();

        burst = $urandom_range(1, 8);
        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            send_value(random_value());
            burst--;
            if (burst == 0)
            begin
                pause_sender($urandom_range(1, 6));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 8);
            end
            if (item == RANDOM_ITEMS / 2)
            begin
                drain_text();
            end
        end

        drain_text();
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/i2a_pkg.sv
src/i2a_if.sv
src/i2a_front.sv
src/i2a_fifo.sv
src/i2a_back.sv
src/int16_decimal_ascii_formatter_top.sv
test/i2a_text_checker.sv
test/tb_int16_decimal_ascii_formatter_top.sv
